FILE: src/cau_pkg.sv
package cau_pkg;

  // Fraction bits of the Q format on all operand and result parts
  localparam int FRAC_BITS = 16;
  // Quotient bits resolved by the divider, one per stage
  localparam int QBITS = 33;
  // Right shift that aligns the scaled numerator with the first quotient bit
  localparam int PRE_SH = QBITS - FRAC_BITS;
  // Pipeline stages: products, sums, divider setup, QBITS divider steps, output
  localparam int NST = QBITS + 4;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_ADDS = 3'd4,
    CMD_SUBS = 3'd5
  } cmd_e;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    fix_t val;
    logic ovf;
  } sat_t;

  // Stage after the multipliers
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic [63:0]        d_rr;
    logic [63:0]        d_ii;
    fix_t               res_re;
    fix_t               res_im;
    logic               ovf;
  } prod_t;

  // Record carried through the divider stages
  typedef struct packed {
    logic [2:0]        cmd;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic [63:0]       n_re;
    logic [63:0]       n_im;
    logic [63:0]       den;
    logic [63:0]       rem_re;
    logic [63:0]       rem_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
    logic              big_re;
    logic              big_im;
    fix_t              res_re;
    fix_t              res_im;
    logic              ovf;
  } dv_t;

  typedef struct packed {
    fix_t res_re;
    fix_t res_im;
    logic ovf;
    logic dz;
  } res_t;

  // Saturate a 33-bit signed sum to 32 bits
  function automatic sat_t sat33(logic signed [32:0] v);
    sat_t r;
    if (v[32] != v[31]) begin
      r.ovf = 1'b1;
      r.val = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 65-bit signed value to 32 bits
  function automatic sat_t sat65(logic signed [64:0] v);
    sat_t r;
    if ((v[64:31] == '0) || (v[64:31] == '1)) begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Apply sign to a quotient magnitude and saturate
  function automatic sat_t divsat(logic neg, logic big, logic [QBITS-1:0] q);
    sat_t             r;
    logic [QBITS-1:0] lim;
    lim = {{(QBITS-32){1'b0}}, 32'h8000_0000};
    r.ovf = 1'b0;
    if (!neg) begin
      if (big || (q >= lim)) begin
        r.ovf = 1'b1;
        r.val = 32'sh7fff_ffff;
      end else begin
        r.val = q[31:0];
      end
    end else begin
      if (big || (q > lim)) begin
        r.ovf = 1'b1;
        r.val = 32'sh8000_0000;
      end else begin
        r.val = 32'(-q[31:0]);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/cau_if.sv
interface cau_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               overflow;
  logic               div_by_zero;

  modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface

FILE: src/complex_arithmetic_unit.sv
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide and
// real-scalar add/subtract, with saturation and overflow / divide-by-zero
// flags. Fully pipelined: one transaction per cycle in and out while the
// output is not stalled. The depth is set by the restoring divider, which
// resolves one quotient bit per stage over 33 stages; all commands travel the
// same pipeline so results leave in order. Each stage holds its data under
// backpressure and empty stages fill up, so input is still taken while a
// finished result waits at the output, as long as some stage is empty.
module complex_arithmetic_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  logic  v_q [NST];
  logic  en  [NST];

  prod_t s1_q, s1_d;
  dv_t   s2_q, s2_d;
  dv_t   dv_q [QBITS+1];
  dv_t   dv_d [QBITS+1];
  res_t  out_q, out_d;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[NST-1];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: products and add/sub results
  always_comb begin
    logic signed [32:0] sr, si;
    sat_t               tr, ti;
    logic               add;
    add = (in_i.command == CMD_ADD) || (in_i.command == CMD_ADDS);
    sr  = add ? (33'(in_i.a_re) + 33'(in_i.b_re)) : (33'(in_i.a_re) - 33'(in_i.b_re));
    si  = add ? (33'(in_i.a_im) + 33'(in_i.b_im)) : (33'(in_i.a_im) - 33'(in_i.b_im));
    tr  = sat33(sr);
    ti  = sat33(si);
    s1_d.cmd  = in_i.command;
    s1_d.p_rr = in_i.a_re * in_i.b_re;
    s1_d.p_ii = in_i.a_im * in_i.b_im;
    s1_d.p_ri = in_i.a_re * in_i.b_im;
    s1_d.p_ir = in_i.a_im * in_i.b_re;
    s1_d.d_rr = in_i.b_re * in_i.b_re;
    s1_d.d_ii = in_i.b_im * in_i.b_im;
    case (in_i.command)
      CMD_ADD, CMD_SUB: begin
        s1_d.res_re = tr.val;
        s1_d.res_im = ti.val;
        s1_d.ovf    = tr.ovf | ti.ovf;
      end
      CMD_ADDS, CMD_SUBS: begin
        s1_d.res_re = tr.val;
        s1_d.res_im = in_i.a_im;
        s1_d.ovf    = tr.ovf;
      end
      default: begin
        s1_d.res_re = '0;
        s1_d.res_im = '0;
        s1_d.ovf    = 1'b0;
      end
    endcase
  end

  // Stage 2: product sums, multiply rescale, divider operands
  always_comb begin
    logic signed [64:0] m_re, m_im, n_re, n_im, a_re, a_im;
    sat_t               tr, ti;
    m_re = 65'(s1_q.p_rr) - 65'(s1_q.p_ii);
    m_im = 65'(s1_q.p_ri) + 65'(s1_q.p_ir);
    n_re = 65'(s1_q.p_rr) + 65'(s1_q.p_ii);
    n_im = 65'(s1_q.p_ir) - 65'(s1_q.p_ri);
    a_re = n_re[64] ? -n_re : n_re;
    a_im = n_im[64] ? -n_im : n_im;
    tr   = sat65(m_re >>> FRAC_BITS);
    ti   = sat65(m_im >>> FRAC_BITS);
    s2_d        = '0;
    s2_d.cmd    = s1_q.cmd;
    s2_d.den    = s1_q.d_rr + s1_q.d_ii;
    s2_d.neg_re = n_re[64];
    s2_d.neg_im = n_im[64];
    s2_d.n_re   = a_re[63:0];
    s2_d.n_im   = a_im[63:0];
    s2_d.dz     = (s1_q.cmd == CMD_DIV) && (s2_d.den == '0);
    if (s1_q.cmd == CMD_MUL) begin
      s2_d.res_re = tr.val;
      s2_d.res_im = ti.val;
      s2_d.ovf    = tr.ovf | ti.ovf;
    end else begin
      s2_d.res_re = s1_q.res_re;
      s2_d.res_im = s1_q.res_im;
      s2_d.ovf    = s1_q.ovf;
    end
  end

  // Divider setup: high part of the scaled numerator, quotient range check
  always_comb begin
    dv_d[0]        = s2_q;
    dv_d[0].rem_re = s2_q.n_re >> PRE_SH;
    dv_d[0].rem_im = s2_q.n_im >> PRE_SH;
    dv_d[0].big_re = dv_d[0].rem_re >= s2_q.den;
    dv_d[0].big_im = dv_d[0].rem_im >= s2_q.den;
    dv_d[0].q_re   = '0;
    dv_d[0].q_im   = '0;
  end

  // Restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int BI = QBITS - 1 - k;
    logic        xb_re, xb_im, ge_re, ge_im;
    logic [64:0] t_re, t_im, dd;

    if (BI >= FRAC_BITS) begin : g_nb
      assign xb_re = dv_q[k].n_re[BI-FRAC_BITS];
      assign xb_im = dv_q[k].n_im[BI-FRAC_BITS];
    end else begin : g_zb
      assign xb_re = 1'b0;
      assign xb_im = 1'b0;
    end

    always_comb begin
      dd    = {1'b0, dv_q[k].den};
      t_re  = {dv_q[k].rem_re, xb_re};
      t_im  = {dv_q[k].rem_im, xb_im};
      ge_re = t_re >= dd;
      ge_im = t_im >= dd;
      dv_d[k+1]        = dv_q[k];
      dv_d[k+1].rem_re = ge_re ? 64'(t_re - dd) : t_re[63:0];
      dv_d[k+1].rem_im = ge_im ? 64'(t_im - dd) : t_im[63:0];
      dv_d[k+1].q_re   = {dv_q[k].q_re[QBITS-2:0], ge_re};
      dv_d[k+1].q_im   = {dv_q[k].q_im[QBITS-2:0], ge_im};
    end
  end

  // Output stage: divide sign and saturation, result select
  always_comb begin
    sat_t tr, ti;
    tr = divsat(dv_q[QBITS].neg_re, dv_q[QBITS].big_re, dv_q[QBITS].q_re);
    ti = divsat(dv_q[QBITS].neg_im, dv_q[QBITS].big_im, dv_q[QBITS].q_im);
    out_d.dz = 1'b0;
    if (dv_q[QBITS].cmd == CMD_DIV) begin
      if (dv_q[QBITS].dz) begin
        out_d.res_re = '0;
        out_d.res_im = '0;
        out_d.ovf    = 1'b0;
        out_d.dz     = 1'b1;
      end else begin
        out_d.res_re = tr.val;
        out_d.res_im = ti.val;
        out_d.ovf    = tr.ovf | ti.ovf;
      end
    end else begin
      out_d.res_re = dv_q[QBITS].res_re;
      out_d.res_im = dv_q[QBITS].res_im;
      out_d.ovf    = dv_q[QBITS].ovf;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    for (int k = 0; k <= QBITS; k++) begin
      if (en[k+2]) dv_q[k] <= dv_d[k];
    end
    if (en[NST-1]) out_q <= out_d;
  end

  assign out_o.res_re      = out_q.res_re;
  assign out_o.res_im      = out_q.res_im;
  assign out_o.overflow    = out_q.ovf;
  assign out_o.div_by_zero = out_q.dz;

endmodule

FILE: src/cau_chk.sv
module cau_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] res_re_i,
  input logic [31:0] res_im_i,
  input logic        overflow_i,
  input logic        div_by_zero_i
);

  // Nothing comes out of reset
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // Input only backs up when the pipeline is full and the output is stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // Divide by zero gives a clean zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && div_by_zero_i) |->
      (res_re_i == 32'h0 && res_im_i == 32'h0 && !overflow_i))
    else $error("divide by zero result not zero");

  // Overflow shows a saturated part
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && overflow_i) |->
      (res_re_i == 32'h7fff_ffff || res_re_i == 32'h8000_0000 ||
       res_im_i == 32'h7fff_ffff || res_im_i == 32'h8000_0000))
    else $error("overflow without saturated part");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(res_re_i) && $stable(res_im_i) &&
       $stable(overflow_i) && $stable(div_by_zero_i)))
    else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_chk u_cau_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .res_re_i      (out_o.res_re),
  .res_im_i      (out_o.res_im),
  .overflow_i    (out_o.overflow),
  .div_by_zero_i (out_o.div_by_zero)
);
